// ----- rtl/pst_pkg.sv -----
// Shared types and constants for the Prim spanning tree block.
package pst_pkg;
  localparam int NodeBits = 5;
  localparam int WeightBits = 16;
  localparam logic [5:0] NodeCountReset = 6'd32;

  // One picked tree edge, queued for output
  typedef struct packed {
    logic [NodeBits-1:0] from_node;
    logic [NodeBits-1:0] to_node;
    logic signed [WeightBits-1:0] weight;
  } pick_t;

  // Status from the engine to the output stage
  typedef struct packed {
    logic done;
    logic spans;
    logic [5:0] pick_count;
  } run_stat_t;
endpackage

// ----- rtl/pst_edge_mem.sv -----
// Edge store: one write port, one registered read port.
module pst_edge_mem import pst_pkg::*; #(
  parameter int Depth = 256,
  parameter int AddrBits = 8
) (
  input  logic clk,
  input  logic we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [2*NodeBits+WeightBits-1:0] wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [2*NodeBits+WeightBits-1:0] rdata
);
  logic [2*NodeBits+WeightBits-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/pst_cand_mem.sv -----
// Candidate store: (from, to, weight, live) entries, one write and one read port.
module pst_cand_mem import pst_pkg::*; #(
  parameter int Depth = 512,
  parameter int AddrBits = 9
) (
  input  logic clk,
  input  logic we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [2*NodeBits+WeightBits:0] wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [2*NodeBits+WeightBits:0] rdata
);
  logic [2*NodeBits+WeightBits:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/prim_spanning_tree_core.sv -----
// Top level of the Prim minimum spanning tree block.
//
//  channel  | signals                                        | dir
//  ---------+------------------------------------------------+-----
//  input    | in_valid/in_ready, end_a end_b edge_weight last_edge | in
//  result   | out_valid/out_ready, tree_from tree_to tree_weight,  | out
//           | edge_valid spanning last_result                      |
//  config   | cfg_we, cfg_data (node_count)                        | in
//
// Loading accepts one request per cycle, back to back. The last edge starts a run:
// each pick is a pass over the candidates (PICK_RD, PICK_W, PICK per entry, then
// KILL to retire the winner); each joined node is a pass over the edge store
// (SCAN_RD, SCAN_W, SCAN per edge) inserting candidates. Results then go out
// one per accepted cycle; in_ready stays low until the last one is taken. Reset
// is synchronous; fill counts guard the stores, so no clearing pass is needed.
module prim_spanning_tree_core import pst_pkg::*; #(
  parameter int MAX_NODES = 32,
  parameter int MAX_EDGES = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [NodeBits-1:0] end_a,
  input  logic [NodeBits-1:0] end_b,
  input  logic signed [WeightBits-1:0] edge_weight,
  input  logic last_edge,
  output logic out_valid,
  input  logic out_ready,
  output logic [NodeBits-1:0] tree_from,
  output logic [NodeBits-1:0] tree_to,
  output logic signed [WeightBits-1:0] tree_weight,
  output logic edge_valid,
  output logic spanning,
  output logic last_result,
  input  logic cfg_we,
  input  logic [5:0] cfg_data
);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CD = 2 * MAX_EDGES;
  localparam int CA = $clog2(CD);
  localparam int EW = 2 * NodeBits + WeightBits;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_W, S_SCAN, S_PICK_RD, S_PICK_W, S_PICK, S_KILL,
    S_SEND
  } state_t;

  state_t state;
  logic [5:0] node_count;
  logic [5:0] n_act;
  logic [EA:0] edge_fill;
  logic [CA:0] cand_fill;
  logic [MAX_NODES-1:0] in_tree;
  logic [5:0] tree_size;
  logic [NodeBits-1:0] cur_node;
  logic [EA:0] eidx;
  logic [CA:0] cidx;
  logic found;
  logic [CA-1:0] best;
  logic signed [WeightBits-1:0] best_w;
  logic pend;                        // second side of an edge still to insert
  logic [EW-1:0] pend_e;
  pick_t picks [MAX_NODES];
  logic [5:0] pick_cnt;
  logic [5:0] send_idx;
  run_stat_t stat;

  logic e_we;
  logic [EA-1:0] e_raddr;
  logic [EW-1:0] e_rdata;
  logic c_we;
  logic [CA-1:0] c_waddr, c_raddr;
  logic [EW:0] c_wdata, c_rdata;

  assign n_act = (node_count == 6'd0) ? 6'd1 :
                 (node_count > 6'(MAX_NODES)) ? 6'(MAX_NODES) : node_count;

  assign e_we = (state == S_IDLE) && in_valid && (6'(end_a) < n_act) &&
                (6'(end_b) < n_act) && (edge_fill < (EA+1)'(MAX_EDGES));

  pst_edge_mem #(.Depth(MAX_EDGES), .AddrBits(EA)) u_edge (
    .clk(clk), .we(e_we), .waddr(edge_fill[EA-1:0]),
    .wdata({end_a, end_b, edge_weight}), .raddr(e_raddr), .rdata(e_rdata));

  pst_cand_mem #(.Depth(CD), .AddrBits(CA)) u_cand (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata));

  // Edge fields of the word read last cycle (or of the held second side)
  logic [NodeBits-1:0] ra, rb;
  logic signed [WeightBits-1:0] rw;
  logic ok_e, ins_a, ins_b;
  always_comb begin
    ra = e_rdata[EW-1 -: NodeBits];
    rb = e_rdata[WeightBits +: NodeBits];
    rw = e_rdata[WeightBits-1:0];
    ok_e = (6'(ra) < n_act) && (6'(rb) < n_act);
    ins_a = ok_e && (ra == cur_node) && !in_tree[rb];
    ins_b = ok_e && (rb == cur_node) && !in_tree[ra];
  end

  logic cand_room;
  assign cand_room = cand_fill < (CA+1)'(CD);

  // Candidate write: insertion during scan, or kill of picked entry
  always_comb begin
    c_we = 1'b0;
    c_waddr = cand_fill[CA-1:0];
    c_wdata = '0;
    if (state == S_SCAN && cand_room) begin
      if (pend) begin
        c_we = 1'b1;
        c_wdata = {1'b1, cur_node, pend_e[EW-1 -: NodeBits], pend_e[WeightBits-1:0]};
      end else if (ins_a) begin
        c_we = 1'b1;
        c_wdata = {1'b1, cur_node, rb, rw};
      end else if (ins_b) begin
        c_we = 1'b1;
        c_wdata = {1'b1, cur_node, ra, rw};
      end
    end else if (state == S_KILL) begin
      c_we = 1'b1;
      c_waddr = best;
      c_wdata = {1'b0, c_rdata[EW-1:0]};
    end
  end

  assign e_raddr = eidx[EA-1:0];
  assign c_raddr = ((state == S_KILL) ||
                    ((state == S_PICK_RD) && (cidx == cand_fill))) ? best : cidx[CA-1:0];

  logic c_live;
  logic [NodeBits-1:0] c_to;
  logic signed [WeightBits-1:0] c_w;
  assign c_live = c_rdata[EW];
  assign c_to = c_rdata[WeightBits +: NodeBits];
  assign c_w = c_rdata[WeightBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_count <= NodeCountReset;
      edge_fill <= '0;
      cand_fill <= '0;
      pick_cnt <= '0;
      send_idx <= '0;
      pend <= 1'b0;
      stat <= '0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (e_we) begin
              edge_fill <= edge_fill + 1'b1;
            end
            if (last_edge) begin
              cand_fill <= '0;
              in_tree <= {{(MAX_NODES-1){1'b0}}, 1'b1};
              tree_size <= 6'd1;
              cur_node <= '0;
              pick_cnt <= '0;
              eidx <= '0;
              pend <= 1'b0;
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          // address eidx is being read; its data is used in S_SCAN, after S_SCAN_W
          if (eidx == edge_fill) begin
            state <= S_PICK_RD;
            cidx <= '0;
            found <= 1'b0;
          end else begin
            state <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (pend) begin
            pend <= 1'b0;
            if (cand_room) cand_fill <= cand_fill + 1'b1;
            eidx <= eidx + 1'b1;
            state <= S_SCAN_RD;
          end else begin
            if ((ins_a || ins_b) && cand_room) cand_fill <= cand_fill + 1'b1;
            if (ins_a && ins_b) begin
              pend <= 1'b1;  // both sides match only for a self loop on cur_node, which in_tree rules out
              pend_e <= e_rdata;
            end else begin
              eidx <= eidx + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end
        S_PICK_RD: begin
          if (tree_size == n_act) begin
            stat <= '{done: 1'b1, spans: 1'b1, pick_count: pick_cnt};
            send_idx <= '0;
            state <= S_SEND;
          end else if (cidx == cand_fill) begin
            if (found) begin
              state <= S_KILL;
            end else begin
              stat <= '{done: 1'b1, spans: 1'b0, pick_count: pick_cnt};
              send_idx <= '0;
              state <= S_SEND;
            end
          end else begin
            state <= S_PICK_W;
          end
        end
        S_PICK_W: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (c_live && (!found || c_w <= best_w)) begin
            found <= 1'b1;
            best <= cidx[CA-1:0];
            best_w <= c_w;
          end
          cidx <= cidx + 1'b1;
          state <= S_PICK_RD;
        end
        S_KILL: begin
          // c_rdata holds entry best (read while scan ended at fill)
          state <= S_PICK_RD;
          cidx <= '0;
          found <= 1'b0;
          if (!in_tree[c_to]) begin
            picks[pick_cnt[$clog2(MAX_NODES)-1:0]] <= '{from_node:
              c_rdata[EW-1 -: NodeBits], to_node: c_to, weight: c_w};
            pick_cnt <= pick_cnt + 1'b1;
            in_tree[c_to] <= 1'b1;
            tree_size <= tree_size + 1'b1;
            cur_node <= c_to;
            eidx <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SEND: begin
          if (out_ready) begin
            if (!stat.spans || stat.pick_count == 6'd0 ||
                send_idx + 1'b1 == stat.pick_count) begin
              state <= S_IDLE;
              edge_fill <= '0;
              cand_fill <= '0;
              stat <= '0;
            end
            send_idx <= send_idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // When the candidate pass reaches the fill count, PICK_RD already reads
  // entry best, so KILL sees the winner on the read port.

  pick_t cur_pick;
  logic real_edge;
  assign cur_pick = picks[send_idx[$clog2(MAX_NODES)-1:0]];
  assign real_edge = stat.spans && (stat.pick_count != 6'd0);
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_SEND);
  assign tree_from = real_edge ? cur_pick.from_node : '0;
  assign tree_to = real_edge ? cur_pick.to_node : '0;
  assign tree_weight = real_edge ? cur_pick.weight : '0;
  assign edge_valid = real_edge;
  assign spanning = stat.spans;
  assign last_result = !real_edge || (send_idx + 1'b1 == stat.pick_count);
endmodule

// ----- dv/tb_prim_spanning_tree_core.sv -----
// Testbench for the Prim spanning tree block: directed and random graphs, self-checking.
`timescale 1ns / 1ps
module tb_prim_spanning_tree_core;
  import pst_pkg::*;

  localparam int NodeMax = 32;
  localparam int EdgeMax = 256;
  localparam int CycleLimit = 2000000;

  // One result as the block should send it
  typedef struct packed {
    logic [NodeBits-1:0] from_node;
    logic [NodeBits-1:0] to_node;
    logic signed [WeightBits-1:0] weight;
    logic has_edge;
    logic spans;
    logic final_one;
  } tree_res_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [NodeBits-1:0] end_a = '0;
  logic [NodeBits-1:0] end_b = '0;
  logic signed [WeightBits-1:0] edge_weight = '0;
  logic last_edge = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [NodeBits-1:0] tree_from;
  logic [NodeBits-1:0] tree_to;
  logic signed [WeightBits-1:0] tree_weight;
  logic edge_valid, spanning, last_result;
  logic cfg_we = 0;
  logic [5:0] cfg_data = '0;

  always #2 clk = ~clk;

  prim_spanning_tree_core dut (.*);

  // Predictor state: the loaded graph and the node count in force
  logic [5:0] node_reg;
  logic [NodeBits-1:0] graph_a[$];
  logic [NodeBits-1:0] graph_b[$];
  logic signed [WeightBits-1:0] graph_w[$];
  tree_res_t tree_expected[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;

  // Effective node count after clamping
  function automatic int span_nodes();
    if (node_reg < 1) return 1;
    if (node_reg > NodeMax) return NodeMax;
    return node_reg;
  endfunction

  // Grow the tree from node 0 and queue the resulting picks
  task automatic grow_tree();
    int n;
    int c_from[$], c_to[$], c_w[$];
    bit c_live[$];
    bit joined[NodeMax];
    int size, best, t;
    bit found;
    tree_res_t r;
    tree_res_t picks[$];
    n = span_nodes();
    foreach (joined[k]) joined[k] = 0;
    joined[0] = 1;
    size = 1;
    t = 0;
    forever begin
      // insert edges of newly joined node t, end_a side first
      for (int i = 0; i < graph_a.size(); i++) begin
        if (graph_a[i] >= n || graph_b[i] >= n) continue;
        if (graph_a[i] == t && !joined[graph_b[i]] && c_from.size() < 2*EdgeMax) begin
          c_from = {c_from, t}; c_to = {c_to, int'(graph_b[i])};
          c_w = {c_w, int'(graph_w[i])}; c_live = {c_live, 1'b1};
        end
        if (graph_b[i] == t && !joined[graph_a[i]] && c_from.size() < 2*EdgeMax) begin
          c_from = {c_from, t}; c_to = {c_to, int'(graph_a[i])};
          c_w = {c_w, int'(graph_w[i])}; c_live = {c_live, 1'b1};
        end
      end
      t = -1;
      while (size != n && t < 0) begin
        found = 0;
        best = 0;
        for (int i = 0; i < c_from.size(); i++)
          if (c_live[i] && (!found || c_w[i] <= c_w[best])) begin
            best = i;
            found = 1;
          end
        if (!found) break;
        c_live[best] = 0;
        if (!joined[c_to[best]]) begin
          t = c_to[best];
          r = '{NodeBits'(c_from[best]), NodeBits'(c_to[best]),
                WeightBits'(c_w[best]), 1'b1, 1'b1, 1'b0};
          picks = {picks, r};
          joined[t] = 1;
          size++;
        end
      end
      if (t < 0) break;
    end
    if (size != n) begin
      r = '{'0, '0, '0, 1'b0, 1'b0, 1'b1};
      tree_expected = {tree_expected, r};
    end else if (picks.size() == 0) begin
      r = '{'0, '0, '0, 1'b0, 1'b1, 1'b1};
      tree_expected = {tree_expected, r};
    end else begin
      picks[$].final_one = 1;
      foreach (picks[i]) tree_expected = {tree_expected, picks[i]};
    end
    graph_a.delete(); graph_b.delete(); graph_w.delete();
  endtask

  // Send one edge request, with random idling beforehand
  task automatic send_edge(int a, int b, int w, bit last);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    end_a <= NodeBits'(a);
    end_b <= NodeBits'(b);
    edge_weight <= WeightBits'(w);
    last_edge <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // model the accepted request
    if (a < span_nodes() && b < span_nodes() && graph_a.size() < EdgeMax) begin
      graph_a = {graph_a, NodeBits'(a)};
      graph_b = {graph_b, NodeBits'(b)};
      graph_w = {graph_w, WeightBits'(w)};
    end
    if (last) grow_tree();
  endtask

  // Wait for all results, then let the block settle before a register write
  task automatic drain();
    in_valid <= 0;
    while (tree_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_nodes(logic [5:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    node_reg = v;
  endtask

  // Random connected-ish graph: a chain of random weights plus extras
  task automatic random_graph(int n, int extra, int wlo, int whi);
    int k;
    for (int i = 1; i < n; i++)
      send_edge($urandom_range(i-1), i, $urandom_range(whi - wlo) + wlo, 0);
    for (k = 0; k < extra; k++)
      send_edge($urandom_range(31), $urandom_range(31),
                $urandom_range(whi - wlo) + wlo, 0);
    send_edge($urandom_range(n-1), $urandom_range(n-1),
              $urandom_range(whi - wlo) + wlo, 1);
  endtask

  task automatic test_directed();
    set_nodes(6'd4);
    // ties: equal weights, latest inserted wins; self loop; out-of-range node
    send_edge(0, 1, 5, 0);
    send_edge(0, 2, 5, 0);
    send_edge(2, 2, -32768, 0);
    send_edge(31, 1, 0, 0);
    send_edge(1, 3, 32767, 0);
    send_edge(3, 2, -32768, 1);
    // no spanning tree
    send_edge(0, 1, 1, 0);
    send_edge(2, 3, 1, 1);
    // single node, and out-of-range values of the register
    set_nodes(6'd1);
    send_edge(0, 0, 7, 1);
    set_nodes(6'd0);
    send_edge(0, 0, -1, 1);
    set_nodes(6'd63);
    send_edge(31, 30, -2, 1);
    set_nodes(6'd2);
    send_edge(1, 0, -32768, 1);
  endtask

  task automatic test_random();
    int n;
    for (int g = 0; g < 16; g++) begin
      n = (g % 5 == 0) ? $urandom_range(32, 20) : $urandom_range(8, 2);
      set_nodes(6'(n));
      no_idle = (g == 6 || g == 7);
      if (g % 4 == 3) random_graph(n, 4, -3, 3);   // many ties
      else random_graph(n, $urandom_range(6), -32768, 32767);
    end
    no_idle = 0;
    // pause until the block is done, then one broken graph
    drain();
    send_edge(5, 6, 1, 0);
    send_edge(0, 1, 1, 1);
  endtask

  // Result checker: random stalls on the receiving side
  always @(posedge clk) begin
    tree_res_t got, exp;
    cycles <= cycles + 1;
    out_ready <= no_idle || $urandom_range(99) >= 17;
    if (!rst && out_valid && out_ready) begin
      got = '{tree_from, tree_to, tree_weight, edge_valid, spanning, last_result};
      if (tree_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp = tree_expected.pop_front();
        if (got !== exp) begin
          $display("%0t: mismatch expected from=%0d to=%0d w=%0d ev=%b sp=%b last=%b",
                   $time, exp.from_node, exp.to_node, exp.weight, exp.has_edge,
                   exp.spans, exp.final_one);
          $display("%0t:          actual   from=%0d to=%0d w=%0d ev=%b sp=%b last=%b",
                   $time, got.from_node, got.to_node, got.weight, got.has_edge,
                   got.spans, got.final_one);
          errors++;
        end
      end
    end
  end

  always @(posedge clk)
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end

  initial begin
    node_reg = NodeCountReset;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    if (errors == 0 && tree_expected.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/pst_pkg.sv
rtl/pst_edge_mem.sv
rtl/pst_cand_mem.sv
rtl/prim_spanning_tree_core.sv
dv/tb_prim_spanning_tree_core.sv
